// ===== hw/rtl/olssc_pkg.sv =====
// Shared constants, types and phase tables for the open-loop six-step commutator.
package olssc_pkg;

   // Field widths
   localparam int SPEED_W    = 16;
   localparam int DUTY_BITS  = 13;
   localparam int TPR_W      = 8;
   localparam int STEP_W     = 3;
   localparam int TICKS_W    = 25;
   localparam int PROD_W     = SPEED_W + TPR_W;

   // Bit-serial divider: 60e6 fits in 26 bits, one quotient bit per cycle
   localparam int                DIV_W     = 26;
   localparam int                DIV_STEPS = DIV_W;
   localparam int                CNT_W     = 5;
   localparam logic [DIV_W-1:0]  DIVIDEND  = 26'd60000000;

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_START_RPM = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_END_RPM   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TPR       = 4'd3;

   // Register reset values
   localparam logic [SPEED_W-1:0]   START_RPM_RST = 16'd60;
   localparam logic [SPEED_W-1:0]   END_RPM_RST   = 16'd600;
   localparam logic [DUTY_BITS-1:0] DUTY_RST      = 13'd327;
   localparam logic [TPR_W-1:0]     TPR_RST       = 8'd21;

   localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
   localparam logic [STEP_W-1:0] STEP_LAST  = 3'd5;

   // Modulated leg codes
   typedef enum logic [1:0] {
      LEG_A = 2'd0,
      LEG_B = 2'd1,
      LEG_C = 2'd2,
      LEG_NONE = 2'd3
   } leg_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_READY = 3'b001,
      ST_MUL   = 3'b010,
      ST_DIV   = 3'b100
   } state_type;

   // Half-bridge enables per step, bit 0 = A, bit 1 = B, bit 2 = C
   function automatic logic [2:0] phase_enables(input logic [STEP_W-1:0] step);
      logic [2:0] en;
      case (step)
         3'd0:    en = 3'b101;
         3'd1:    en = 3'b011;
         3'd2:    en = 3'b110;
         3'd3:    en = 3'b101;
         3'd4:    en = 3'b011;
         3'd5:    en = 3'b110;
         default: en = 3'b000;
      endcase
      return en;
   endfunction

   // Leg that carries the duty compare per step
   function automatic leg_type phase_leg(input logic [STEP_W-1:0] step);
      leg_type leg;
      case (step)
         3'd0, 3'd1: leg = LEG_A;
         3'd2, 3'd3: leg = LEG_C;
         3'd4, 3'd5: leg = LEG_B;
         default:    leg = LEG_NONE;
      endcase
      return leg;
   endfunction

endpackage

// ===== hw/rtl/open_loop_six_step_commutator.sv =====
// Open-loop six-step commutator: one registered result for each accepted tick.
// A tick that does not start a phase is taken every cycle while results drain.
// A phase start runs a multiply state then a bit-serial divider for the phase
// length, and no further tick is taken until the divider has finished.
// Synchronous reset restores the register defaults, idles the sequencer and
// empties the result register; no clearing pass is needed.
module open_loop_six_step_commutator import olssc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // tick channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_run,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_enable_a,
   output logic                  rsp_enable_b,
   output logic                  rsp_enable_c,
   output logic [DUTY_BITS-1:0]  rsp_duty_a,
   output logic [DUTY_BITS-1:0]  rsp_duty_b,
   output logic [DUTY_BITS-1:0]  rsp_duty_c,
   output logic [STEP_W-1:0]     rsp_phase,
   output logic [SPEED_W-1:0]    rsp_speed_rpm,
   output logic                  rsp_commutated,
   // configuration port
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [SPEED_W-1:0]   start_rpm_ff, start_rpm_in;
   logic [SPEED_W-1:0]   end_rpm_ff, end_rpm_in;
   logic [DUTY_BITS-1:0] duty_ff, duty_in;
   logic [TPR_W-1:0]     tpr_ff, tpr_in;

   // Commutation state
   state_type            state_ff, state_in;
   logic                 active_ff, active_in;
   logic [SPEED_W-1:0]   speed_ff, speed_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [TICKS_W-1:0]   remain_ff, remain_in;
   logic [TPR_W-1:0]     tpr_lat_ff, tpr_lat_in;

   // Divider datapath
   logic [TICKS_W-1:0]   divisor_ff, divisor_in;
   logic [TICKS_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]     dsr_ff, dsr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           en_ff, en_in;
   logic [DUTY_BITS-1:0] duty_a_ff, duty_a_in;
   logic [DUTY_BITS-1:0] duty_b_ff, duty_b_in;
   logic [DUTY_BITS-1:0] duty_c_ff, duty_c_in;
   logic [STEP_W-1:0]    phase_ff, phase_in;
   logic [SPEED_W-1:0]   spd_out_ff, spd_out_in;
   logic                 comm_ff, comm_in;

   // Tick decode
   logic                 req_fire;
   logic                 phase_start;
   logic [STEP_W-1:0]    step_nx;
   logic                 ramp;
   logic [SPEED_W-1:0]   speed_ramp;
   logic [STEP_W-1:0]    tick_step;
   leg_type              tick_leg;

   // Divider step
   logic [SPEED_W-1:0]   speed_eff;
   logic [TPR_W-1:0]     tpr_eff;
   logic [PROD_W-1:0]    prod;
   logic [DIV_W-1:0]     rem_shift;
   logic [DIV_W-1:0]     rem_diff;
   logic                 qbit;
   logic [TICKS_W-1:0]   quot_lo;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_READY) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   // Next step and ramped speed for a phase start
   assign phase_start = !active_ff || (remain_ff == '0);
   assign step_nx     = !active_ff ? STEP_FIRST :
                        (step_ff == STEP_LAST) ? STEP_FIRST : step_ff + 1'b1;
   assign ramp        = (step_nx == STEP_FIRST) && (speed_ff <= end_rpm_ff) &&
                        (speed_ff != '1);
   assign speed_ramp  = ramp ? speed_ff + 1'b1 : speed_ff;
   assign tick_step   = phase_start ? step_nx : step_ff;
   assign tick_leg    = phase_leg(tick_step);

   // Phase length product, zero operands taken as one
   assign speed_eff = (speed_ff == '0) ? SPEED_W'(1) : speed_ff;
   assign tpr_eff   = (tpr_lat_ff == '0) ? TPR_W'(1) : tpr_lat_ff;
   assign prod      = PROD_W'(speed_eff) * PROD_W'(tpr_eff);

   // One restoring division step: bring in the next dividend bit
   assign rem_shift = {rem_ff, dsr_ff[DIV_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign qbit      = (rem_shift >= {1'b0, divisor_ff});
   assign quot_lo   = {dsr_ff[TICKS_W-2:0], qbit};

   // Configuration writes
   always_comb begin
      start_rpm_in = start_rpm_ff;
      end_rpm_in   = end_rpm_ff;
      duty_in      = duty_ff;
      tpr_in       = tpr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_START_RPM: start_rpm_in = csr_wdata[SPEED_W-1:0];
            REG_END_RPM:   end_rpm_in   = csr_wdata[SPEED_W-1:0];
            REG_DUTY:      duty_in      = csr_wdata[DUTY_BITS-1:0];
            REG_TPR:       tpr_in       = csr_wdata[TPR_W-1:0];
            default:       ;
         endcase
      end
   end

   // Tick handling and divider sequencing
   always_comb begin
      state_in   = state_ff;
      active_in  = active_ff;
      speed_in   = speed_ff;
      step_in    = step_ff;
      remain_in  = remain_ff;
      tpr_lat_in = tpr_lat_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      dsr_in     = dsr_ff;
      cnt_in     = cnt_ff;
      case (state_ff)
         ST_READY: begin
            if (req_fire) begin
               if (!req_run) begin
                  active_in = 1'b0;
                  speed_in  = start_rpm_ff;
                  step_in   = STEP_FIRST;
                  remain_in = '0;
               end else if (phase_start) begin
                  active_in  = 1'b1;
                  step_in    = step_nx;
                  speed_in   = speed_ramp;
                  tpr_lat_in = tpr_ff;
                  state_in   = ST_MUL;
               end else begin
                  remain_in = remain_ff - 1'b1;
               end
            end
         end
         ST_MUL: begin
            divisor_in = {prod, 1'b0};
            rem_in     = '0;
            dsr_in     = DIVIDEND;
            cnt_in     = CNT_W'(DIV_STEPS - 1);
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in = qbit ? rem_diff[TICKS_W-1:0] : rem_shift[TICKS_W-1:0];
            dsr_in = {dsr_ff[DIV_W-2:0], qbit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // tick that starts the phase counts as its first
               remain_in = quot_lo - 1'b1;
               state_in  = ST_READY;
            end
         end
         default: state_in = ST_READY;
      endcase
   end

   // Result register, loaded on each accepted tick
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      en_in        = en_ff;
      duty_a_in    = duty_a_ff;
      duty_b_in    = duty_b_ff;
      duty_c_in    = duty_c_ff;
      phase_in     = phase_ff;
      spd_out_in   = spd_out_ff;
      comm_in      = comm_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         en_in        = '0;
         duty_a_in    = '0;
         duty_b_in    = '0;
         duty_c_in    = '0;
         phase_in     = STEP_FIRST;
         spd_out_in   = start_rpm_ff;
         comm_in      = 1'b0;
         if (req_run) begin
            en_in      = phase_enables(tick_step);
            phase_in   = tick_step;
            spd_out_in = phase_start ? speed_ramp : speed_ff;
            comm_in    = phase_start;
            case (tick_leg)
               LEG_A:   duty_a_in = duty_ff;
               LEG_B:   duty_b_in = duty_ff;
               LEG_C:   duty_c_in = duty_ff;
               default: ;
            endcase
         end
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_rpm_ff <= START_RPM_RST;
         end_rpm_ff   <= END_RPM_RST;
         duty_ff      <= DUTY_RST;
         tpr_ff       <= TPR_RST;
         state_ff     <= ST_READY;
         active_ff    <= 1'b0;
         speed_ff     <= START_RPM_RST;
         step_ff      <= STEP_FIRST;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_rpm_ff <= start_rpm_in;
         end_rpm_ff   <= end_rpm_in;
         duty_ff      <= duty_in;
         tpr_ff       <= tpr_in;
         state_ff     <= state_in;
         active_ff    <= active_in;
         speed_ff     <= speed_in;
         step_ff      <= step_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and payload registers
   always_ff @(posedge clock) begin
      tpr_lat_ff <= tpr_lat_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      dsr_ff     <= dsr_in;
      cnt_ff     <= cnt_in;
      en_ff      <= en_in;
      duty_a_ff  <= duty_a_in;
      duty_b_ff  <= duty_b_in;
      duty_c_ff  <= duty_c_in;
      phase_ff   <= phase_in;
      spd_out_ff <= spd_out_in;
      comm_ff    <= comm_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_enable_a   = en_ff[0];
   assign rsp_enable_b   = en_ff[1];
   assign rsp_enable_c   = en_ff[2];
   assign rsp_duty_a     = duty_a_ff;
   assign rsp_duty_b     = duty_b_ff;
   assign rsp_duty_c     = duty_c_ff;
   assign rsp_phase      = phase_ff;
   assign rsp_speed_rpm  = spd_out_ff;
   assign rsp_commutated = comm_ff;

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the open-loop six-step commutator: ticks checked against a cycle-free predictor.
`timescale 1ns / 100ps

module tb_top;
   import olssc_pkg::*;

   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 500;
   localparam int NUM_SETTINGS  = 9;
   localparam int MAX_PRINTS    = 30;
   localparam longint unsigned TICKS_PER_MIN = 64'd60000000;
   // Index with no register behind it
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 4'd9;

   // One commutation result as the block presents it
   typedef struct packed {
      logic                 en_a;
      logic                 en_b;
      logic                 en_c;
      logic [DUTY_BITS-1:0] duty_a;
      logic [DUTY_BITS-1:0] duty_b;
      logic [DUTY_BITS-1:0] duty_c;
      logic [STEP_W-1:0]    phase;
      logic [SPEED_W-1:0]   speed;
      logic                 commutated;
   } drive_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_run = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_enable_a;
   logic                  rsp_enable_b;
   logic                  rsp_enable_c;
   logic [DUTY_BITS-1:0]  rsp_duty_a;
   logic [DUTY_BITS-1:0]  rsp_duty_b;
   logic [DUTY_BITS-1:0]  rsp_duty_c;
   logic [STEP_W-1:0]     rsp_phase;
   logic [SPEED_W-1:0]    rsp_speed_rpm;
   logic                  rsp_commutated;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Register copies and commutation state of the predictor
   logic [SPEED_W-1:0]   cfg_start = START_RPM_RST;
   logic [SPEED_W-1:0]   cfg_end   = END_RPM_RST;
   logic [DUTY_BITS-1:0] cfg_duty  = DUTY_RST;
   logic [TPR_W-1:0]     cfg_tpr   = TPR_RST;
   logic                 spin_active = 1'b0;
   logic [SPEED_W-1:0]   spin_speed  = START_RPM_RST;
   logic [STEP_W-1:0]    spin_step   = STEP_FIRST;
   logic [TICKS_W-1:0]   spin_left   = '0;

   logic          tick_q[$];
   drive_out_type drive_expected_q[$];
   drive_out_type seen_r;
   drive_out_type want_r;

   int ticks_queued   = 0;
   int ticks_accepted = 0;
   int results_done   = 0;
   int fail_count     = 0;
   int send_idle_pct  = 14;
   int recv_idle_pct  = 52;
   int hold_left      = 0;
   int quiet_cycles   = 0;
   logic hold_go    = 1'b0;
   logic hold_taken = 1'b0;

   open_loop_six_step_commutator dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Next result of the commutator for one tick; advances the predictor state
   function automatic drive_out_type commutate_tick(input logic run);
      drive_out_type r;
      longint unsigned s;
      longint unsigned t;
      longint unsigned len;
      leg_type leg;
      r = '0;
      if (!run) begin
         spin_active = 1'b0;
         spin_speed  = cfg_start;
         spin_step   = STEP_FIRST;
         spin_left   = '0;
         r.speed     = spin_speed;
         return r;
      end
      if (!spin_active || spin_left == '0) begin
         if (!spin_active)
            spin_step = STEP_FIRST;
         else if (spin_step >= STEP_LAST)
            spin_step = STEP_FIRST;
         else
            spin_step = spin_step + 1'b1;
         spin_active = 1'b1;
         // ramp only on entering step 0, saturating at full scale
         if (spin_step == STEP_FIRST && spin_speed <= cfg_end && spin_speed != '1)
            spin_speed = spin_speed + 1'b1;
         s = (spin_speed == '0) ? 64'd1 : 64'(spin_speed);
         t = (cfg_tpr == '0) ? 64'd1 : 64'(cfg_tpr);
         len = TICKS_PER_MIN / (64'd2 * t * s);
         spin_left = TICKS_W'(len - 64'd1);
         r.commutated = 1'b1;
      end else begin
         spin_left = spin_left - 1'b1;
      end
      // enables A B C and modulated leg per step
      case (spin_step)
         3'd0: begin {r.en_a, r.en_b, r.en_c} = 3'b101; leg = LEG_A; end
         3'd1: begin {r.en_a, r.en_b, r.en_c} = 3'b110; leg = LEG_A; end
         3'd2: begin {r.en_a, r.en_b, r.en_c} = 3'b011; leg = LEG_C; end
         3'd3: begin {r.en_a, r.en_b, r.en_c} = 3'b101; leg = LEG_C; end
         3'd4: begin {r.en_a, r.en_b, r.en_c} = 3'b110; leg = LEG_B; end
         3'd5: begin {r.en_a, r.en_b, r.en_c} = 3'b011; leg = LEG_B; end
         default: leg = LEG_NONE;
      endcase
      case (leg)
         LEG_A:   r.duty_a = cfg_duty;
         LEG_B:   r.duty_b = cfg_duty;
         LEG_C:   r.duty_c = cfg_duty;
         default: ;
      endcase
      r.phase = spin_step;
      r.speed = spin_speed;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, results_done);
   endtask

   task automatic queue_tick(input logic run);
      tick_q.push_back(run);
      ticks_queued++;
   endtask

   // One register write; the predictor copy follows on acceptance
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_START_RPM: cfg_start = data;
         REG_END_RPM:   cfg_end   = data;
         REG_DUTY:      cfg_duty  = data[DUTY_BITS-1:0];
         REG_TPR:       cfg_tpr   = data[TPR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] start_v,
                                input logic [CSR_DATA_W-1:0] end_v,
                                input logic [CSR_DATA_W-1:0] duty_v,
                                input logic [CSR_DATA_W-1:0] tpr_v);
      write_reg(REG_START_RPM, start_v);
      write_reg(REG_END_RPM, end_v);
      write_reg(REG_DUTY, duty_v);
      write_reg(REG_TPR, tpr_v);
   endtask

   // Every queued tick taken and answered, then let a phase start finish
   task automatic wait_drained();
      while (ticks_accepted != ticks_queued || results_done != ticks_accepted)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Tick driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            drive_expected_q.push_back(commutate_tick(req_run));
            ticks_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (tick_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_run   <= tick_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_r = {rsp_enable_a, rsp_enable_b, rsp_enable_c, rsp_duty_a, rsp_duty_b,
                      rsp_duty_c, rsp_phase, rsp_speed_rpm, rsp_commutated};
            if (drive_expected_q.size() == 0) begin
               report_mismatch("result with nothing expected", 0, 0);
            end else begin
               want_r = drive_expected_q.pop_front();
               if (seen_r.en_a !== want_r.en_a)
                  report_mismatch("enable_a", seen_r.en_a, want_r.en_a);
               if (seen_r.en_b !== want_r.en_b)
                  report_mismatch("enable_b", seen_r.en_b, want_r.en_b);
               if (seen_r.en_c !== want_r.en_c)
                  report_mismatch("enable_c", seen_r.en_c, want_r.en_c);
               if (seen_r.duty_a !== want_r.duty_a)
                  report_mismatch("duty_a", seen_r.duty_a, want_r.duty_a);
               if (seen_r.duty_b !== want_r.duty_b)
                  report_mismatch("duty_b", seen_r.duty_b, want_r.duty_b);
               if (seen_r.duty_c !== want_r.duty_c)
                  report_mismatch("duty_c", seen_r.duty_c, want_r.duty_c);
               if (seen_r.phase !== want_r.phase)
                  report_mismatch("phase", seen_r.phase, want_r.phase);
               if (seen_r.speed !== want_r.speed)
                  report_mismatch("speed_rpm", seen_r.speed, want_r.speed);
               if (seen_r.commutated !== want_r.commutated)
                  report_mismatch("commutated", seen_r.commutated, want_r.commutated);
               results_done++;
            end
         end
         // long hold-off once, else random stalls
         if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            rsp_ready  <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Stimulus
   initial begin
      int n;
      int burst;
      int e_rpm;
      logic [CSR_DATA_W-1:0] s_rpm;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: idle, leaving idle, idle reload
      queue_tick(1'b0);
      queue_tick(1'b1);
      queue_tick(1'b1);
      queue_tick(1'b1);
      queue_tick(1'b0);
      queue_tick(1'b1);
      queue_tick(1'b1);
      wait_drained();

      // one-tick phases at full speed: all six steps, ramp saturates, duty bits masked
      apply_setting(16'd65534, 16'hFFFF, 16'hFFFF, 16'd255);
      queue_tick(1'b0);
      repeat (9) queue_tick(1'b1);
      queue_tick(1'b0);
      wait_drained();

      // zero divisor and zero start speed; spare index must change nothing
      apply_setting(16'd0, 16'd0, 16'd0, 16'd0);
      write_reg(REG_SPARE, 16'hFFFF);
      queue_tick(1'b1);
      queue_tick(1'b1);
      queue_tick(1'b0);
      wait_drained();

      // start speed and transition count of one
      apply_setting(16'd1, 16'd1, 16'd4096, 16'd1);
      queue_tick(1'b1);
      queue_tick(1'b1);
      queue_tick(1'b0);
      wait_drained();

      // random runs under a series of settings
      for (int k = 0; k < NUM_SETTINGS; k++) begin
         if (k < 3) begin
            send_idle_pct <= 14;
            recv_idle_pct <= 52;
         end else if (k < 6) begin
            send_idle_pct <= 52;
            recv_idle_pct <= 14;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         case (k)
            0: apply_setting(16'd20000, 16'd20001, 16'd4096, 16'd255);
            1: apply_setting(16'd65534, 16'hFFFF, 16'($urandom_range(65535, 0)), 16'd255);
            2: apply_setting(16'd30000, 16'd1, 16'($urandom_range(65535, 0)), 16'd200);
            default: begin
               s_rpm = 16'($urandom_range(65535, 4000));
               e_rpm = int'(s_rpm) + $urandom_range(3, 0);
               if (e_rpm > 65535)
                  e_rpm = 65535;
               if ($urandom_range(3, 0) == 0)
                  e_rpm = $urandom_range(int'(s_rpm), 1);
               apply_setting(s_rpm, 16'(e_rpm), 16'($urandom_range(65535, 0)),
                             16'($urandom_range(255, 100)));
            end
         endcase
         if (k == 6)
            hold_go <= 1'b1;
         n = 0;
         while (n < RANDOM_ITEMS / NUM_SETTINGS) begin
            burst = $urandom_range(40, 4);
            repeat (burst) queue_tick(1'b1);
            n += burst;
            case ($urandom_range(3, 0))
               0: begin
                  queue_tick(1'b0);
                  n++;
               end
               1: begin
                  burst = $urandom_range(3, 1);
                  repeat (burst) queue_tick(1'($urandom_range(1, 0)));
                  n += burst;
               end
               default: ;
            endcase
         end
         wait_drained();
      end

      if (drive_expected_q.size() != 0)
         report_mismatch("results never delivered", drive_expected_q.size(), 0);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/olssc_pkg.sv
hw/rtl/open_loop_six_step_commutator.sv
verif/tb_top.sv
